[sv/assert_macros.svh]
// assertion macros shared by the address range lookup modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

[sv/arlu_pkg.sv]
// shared types and constants of the address range lookup unit
package arlu_pkg;

  localparam int INDEX_WIDTH = 10;
  localparam int COUNT_WIDTH = 11;
  localparam int FIELD_ADDR_WIDTH = 64;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic                        command;
    logic [INDEX_WIDTH-1:0]      entry_index;
    logic [FIELD_ADDR_WIDTH-1:0] range_start;
    logic [FIELD_ADDR_WIDTH-1:0] range_end;
    logic [FIELD_ADDR_WIDTH-1:0] lookup_address;
  } request_t;

  typedef struct packed {
    logic                   hit;
    logic [INDEX_WIDTH-1:0] hit_index;
  } response_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOP,
    ST_CMP,
    ST_CHECK
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic write_en;
    logic load;
    logic rd_en;
    logic at_mid;
    logic update;
    logic finish;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic step;
  } ctl_status_t;

endpackage

[sv/arlu_ctrl.sv]
// sequencer of the binary search: idle, step issue, step compare, final check
`include "assert_macros.svh"
module arlu_ctrl
  import arlu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        command,
  input  ctl_status_t status,
  output logic        busy,
  output ctl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (command == CMD_LOOKUP) begin
            cmd.load   = 1'b1;
            state_next = ST_LOOP;
          end else begin
            cmd.write_en = 1'b1;
          end
        end
      end
      ST_LOOP: begin
        // read the midpoint for another step, or the final candidate
        cmd.rd_en = 1'b1;
        if (status.step) begin
          cmd.at_mid = 1'b1;
          state_next = ST_CMP;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CMP: begin
        cmd.update = 1'b1;
        state_next = ST_LOOP;
      end
      ST_CHECK: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `ASSERT_NEVER(a_no_load_when_busy, clk, rst, busy && (cmd.load || cmd.write_en))
  `ASSERT_HOLDS(a_cmp_after_mid_read, clk, rst, (cmd.rd_en && cmd.at_mid) |=> cmd.update)
  `ASSERT_HOLDS(a_finish_to_idle, clk, rst, cmd.finish |=> !busy)

endmodule

[sv/arlu_datapath.sv]
// range table memory, search bounds, key compare and result register
`include "assert_macros.svh"
module arlu_datapath
  import arlu_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int ADDR_WIDTH  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  request_t               request,
  input  logic                   cfg_write,
  input  logic [COUNT_WIDTH-1:0] cfg_data,
  input  ctl_cmd_t               cmd,
  output ctl_status_t            status,
  output logic                   response_valid,
  output response_t              response
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CW    = $clog2(TABLE_DEPTH + 1);

  logic [2*ADDR_WIDTH-1:0] mem [TABLE_DEPTH];
  logic [2*ADDR_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0]  count;
  logic [ADDR_WIDTH-1:0]   key;
  logic [CW-1:0]           low;
  logic [CW-1:0]           high;
  logic [CW-1:0]           mid_q;
  logic                    eq_done;
  logic                    empty;

  logic [CW-1:0]         n_sat;
  logic [CW-1:0]         mid;
  logic                  more;
  logic [ADDR_WIDTH-1:0] rd_start;
  logic [ADDR_WIDTH-1:0] rd_end;
  logic                  slot_ok;
  logic [IDX_W-1:0]      rd_addr;
  logic                  found;

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cfg_write) begin
      count <= cfg_data;
    end
  end

  // saturated count and midpoint
  always_comb begin
    if (32'(count) > TABLE_DEPTH) begin
      n_sat = CW'(TABLE_DEPTH);
    end else begin
      n_sat = CW'(count);
    end
    mid  = low + ((high - low) >> 1);
    more = ({1'b0, low} + (CW+1)'(1)) < {1'b0, high};
  end

  assign status.step = more && !eq_done;
  assign rd_start    = rdata[2*ADDR_WIDTH-1:ADDR_WIDTH];
  assign rd_end      = rdata[ADDR_WIDTH-1:0];
  assign slot_ok     = 32'(request.entry_index) < TABLE_DEPTH;
  assign rd_addr     = cmd.at_mid ? mid[IDX_W-1:0] : low[IDX_W-1:0];

  // table memory, one write or one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.write_en && slot_ok) begin
      mem[IDX_W'(request.entry_index)] <=
        {request.range_start[ADDR_WIDTH-1:0], request.range_end[ADDR_WIDTH-1:0]};
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // search bounds
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key     <= request.lookup_address[ADDR_WIDTH-1:0];
      low     <= '0;
      high    <= n_sat;
      empty   <= (n_sat == '0);
      eq_done <= 1'b0;
    end else if (cmd.update) begin
      if (key < rd_start) begin
        high <= mid_q;
      end else begin
        low     <= mid_q;
        eq_done <= (key == rd_start);
      end
    end
    if (cmd.rd_en && cmd.at_mid) begin
      mid_q <= mid;
    end
  end

  // final range check and result strobe
  assign found = !empty && (rd_start <= key) && (key <= rd_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      response_valid <= 1'b0;
    end else begin
      response_valid <= cmd.finish;
    end
    if (cmd.finish) begin
      response.hit       <= found;
      response.hit_index <= found ? INDEX_WIDTH'(low) : '0;
    end
  end

  `ASSERT_HOLDS(a_single_strobe, clk, rst, response_valid |=> !response_valid)
  `ASSERT_NEVER(a_mid_inside, clk, rst,
    cmd.rd_en && cmd.at_mid && ((mid <= low) || (mid >= high)))
  `ASSERT_NEVER(a_low_below_depth, clk, rst, cmd.rd_en && (32'(low) >= TABLE_DEPTH))

endmodule

[sv/address_range_lookup_unit.sv]
// Address range lookup: a write gives no result.
// A lookup strobes its result after S search steps and a final check, S being at most
// ceil(log2 n) (10 at 1024 entries); each step is one registered table read
// and one compare, so the single memory read port sets the rate.
// The next item is accepted at the edge ending the strobe.
// No receiver stall; reset clears the sequencer and entry_count, not the table.
module address_range_lookup_unit
  import arlu_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int ADDR_WIDTH  = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  request_t               request,
  input  logic                   cfg_write,
  input  logic [COUNT_WIDTH-1:0] cfg_data,
  output logic                   response_valid,
  output response_t              response
);

  ctl_cmd_t    cmd;
  ctl_status_t status;

  // sequencer
  arlu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  // table and search datapath
  arlu_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .request        (request),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .status         (status),
    .response_valid (response_valid),
    .response       (response)
  );

endmodule

[dv/tb.sv]
// testbench for the address range lookup unit: directed table, then randomized lookups
module tb;
  import arlu_pkg::*;

  localparam int TABLE_SLOTS = 1024;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int FULL_LOAD_LIMIT = 48;
  localparam int SMALL_PHASE_ITEMS = 16;
  localparam int LARGE_PHASE_ITEMS = 6;
  localparam logic [63:0] ALL_ONES = {64{1'b1}};
  localparam logic [63:0] HIGH_HALF = 64'h8000_0000_0000_0000;
  localparam logic [63:0] FILL_OFFSET_MASK = (64'd1 << 53) - 64'd1;

  typedef enum {ROW_CONFIG, ROW_WRITE, ROW_LOOKUP} row_kind_t;

  // value is the slot of a write or the count of a config write,
  // first is the range start or the lookup address
  typedef struct {
    row_kind_t   kind;
    int unsigned value;
    logic [63:0] first;
    logic [63:0] last;
    bit          typed;
    bit          exp_hit;
    int unsigned exp_index;
  } directed_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  request_t               request = '0;
  logic                   cfg_write = 1'b0;
  logic [COUNT_WIDTH-1:0] cfg_data = '0;
  logic                   response_valid;
  response_t              response;

  // table mirror and search setting
  logic [63:0]            start_mirror [TABLE_SLOTS];
  logic [63:0]            end_mirror [TABLE_SLOTS];
  bit                     written_slot [TABLE_SLOTS];
  logic [COUNT_WIDTH-1:0] entry_count_cfg = '0;

  response_t pending_lookups [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        steady_sender = 1'b0;
  int        extreme_counts [7] = '{0, 1, 2, 3, 1024, 2047, 1023};

  directed_row_t directed_rows [22] = '{
    '{ROW_LOOKUP, 0, 64'h0, 64'h0, 1'b1, 1'b0, 0},
    '{ROW_LOOKUP, 0, ALL_ONES, 64'h0, 1'b1, 1'b0, 0},
    '{ROW_WRITE, 0, 64'h0, 64'hF, 1'b0, 1'b0, 0},
    '{ROW_WRITE, 1, 64'h100, 64'h1FF, 1'b0, 1'b0, 0},
    '{ROW_WRITE, 2, HIGH_HALF, ALL_ONES, 1'b0, 1'b0, 0},
    '{ROW_WRITE, 1023, ALL_ONES, ALL_ONES, 1'b0, 1'b0, 0},
    '{ROW_LOOKUP, 0, 64'h5, 64'h0, 1'b1, 1'b0, 0},
    '{ROW_CONFIG, 1, 64'h0, 64'h0, 1'b0, 1'b0, 0},
    '{ROW_LOOKUP, 0, 64'h0, 64'h0, 1'b1, 1'b1, 0},
    '{ROW_LOOKUP, 0, 64'h10, 64'h0, 1'b1, 1'b0, 0},
    '{ROW_LOOKUP, 0, ALL_ONES, 64'h0, 1'b1, 1'b0, 0},
    '{ROW_CONFIG, 3, 64'h0, 64'h0, 1'b0, 1'b0, 0},
    '{ROW_LOOKUP, 0, 64'h100, 64'h0, 1'b1, 1'b1, 1},
    '{ROW_LOOKUP, 0, 64'h1FF, 64'h0, 1'b0, 1'b0, 0},
    '{ROW_LOOKUP, 0, 64'h200, 64'h0, 1'b0, 1'b0, 0},
    '{ROW_LOOKUP, 0, ALL_ONES, 64'h0, 1'b1, 1'b1, 2},
    '{ROW_LOOKUP, 0, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 1'b0, 0},
    '{ROW_WRITE, 0, 64'h50, 64'h40, 1'b0, 1'b0, 0},
    '{ROW_LOOKUP, 0, 64'h48, 64'h0, 1'b0, 1'b0, 0},
    '{ROW_WRITE, 1, 64'h9000_0000_0000_0000, 64'h9000_0000_0000_00FF, 1'b0, 1'b0, 0},
    '{ROW_LOOKUP, 0, 64'h9000_0000_0000_0010, 64'h0, 1'b0, 1'b0, 0},
    '{ROW_LOOKUP, 0, 64'h60, 64'h0, 1'b0, 1'b0, 0}
  };

  address_range_lookup_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .response_valid (response_valid),
    .response       (response)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic request_t make_request(logic cmd, logic [INDEX_WIDTH-1:0] slot,
                                            logic [63:0] first, logic [63:0] last,
                                            logic [63:0] addr);
    request_t req;
    req.command        = cmd;
    req.entry_index    = slot;
    req.range_start    = first;
    req.range_end      = last;
    req.lookup_address = addr;
    return req;
  endfunction

  // number of slots a lookup searches, saturated at the table depth
  function automatic int searched_slots();
    return (entry_count_cfg > TABLE_SLOTS) ? TABLE_SLOTS : int'(entry_count_cfg);
  endfunction

  // binary search for the last slot whose start is not above the key
  function automatic response_t search_ranges(logic [63:0] key);
    int        span;
    int        low;
    int        high;
    int        mid;
    bit        done;
    response_t found;
    span  = searched_slots();
    low   = 0;
    high  = span;
    done  = 1'b0;
    found = '0;
    while (!done && low + 1 < high) begin
      mid = low + ((high - low) >> 1);
      if (key < start_mirror[mid]) begin
        high = mid;
      end else begin
        low = mid;
        if (key == start_mirror[mid]) done = 1'b1;
      end
    end
    if (span > 0 && start_mirror[low] <= key && end_mirror[low] >= key) begin
      found.hit       = 1'b1;
      found.hit_index = INDEX_WIDTH'(low);
    end
    return found;
  endfunction

  // present one item, wait for it to be taken, then update the mirror for a write or queue the expected lookup result
  task automatic issue(input request_t req, input bit typed, input response_t typed_result);
    while (!steady_sender && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (req.command == CMD_WRITE) begin
      start_mirror[req.entry_index] = req.range_start;
      end_mirror[req.entry_index]   = req.range_end;
      written_slot[req.entry_index] = 1'b1;
    end else begin
      pending_lookups.push_back(typed ? typed_result : search_ranges(req.lookup_address));
    end
  endtask

  // write one slot of a large table if it was never written, ascending with the slot
  task automatic fill_slot(input int slot);
    logic [63:0] first;
    if (written_slot[slot]) return;
    first = (64'(slot) << 54) | (random_word() & FILL_OFFSET_MASK);
    issue(make_request(CMD_WRITE, INDEX_WIDTH'(slot), first,
                       first + (random_word() & FILL_OFFSET_MASK), random_word()), 1'b0, '0);
  endtask

  // write every slot the search for this key will read
  task automatic fill_path(input logic [63:0] key);
    int low;
    int high;
    int mid;
    bit done;
    low  = 0;
    high = searched_slots();
    done = 1'b0;
    while (!done && low + 1 < high) begin
      mid = low + ((high - low) >> 1);
      fill_slot(mid);
      if (key < start_mirror[mid]) begin
        high = mid;
      end else begin
        low = mid;
        if (key == start_mirror[mid]) done = 1'b1;
      end
    end
    if (high > 0) fill_slot(low);
  endtask

  // change the search count once the unit has gone quiet
  task automatic set_entry_count(input logic [COUNT_WIDTH-1:0] value);
    start <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    // a write in flight gives no result, so allow it time to finish
    repeat (4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write       <= 1'b0;
    entry_count_cfg  = value;
  endtask

  // write slots 0..span-1 with ascending ranges on a random stride
  task automatic load_sorted_ranges(input int span);
    int          shift;
    logic [63:0] stride;
    logic [63:0] offset_mask;
    logic [63:0] base;
    logic [63:0] first;
    shift       = $urandom_range(1, 53);
    stride      = 64'd1 << shift;
    offset_mask = (stride >> 1) - 64'd1;
    base        = ($urandom_range(0, 3) == 0) ? 64'd0
                : random_word() & ~((64'd1 << (shift + 11)) - 64'd1);
    for (int slot = 0; slot < span; slot++) begin
      first = base + 64'(slot) * stride + (random_word() & offset_mask);
      issue(make_request(CMD_WRITE, INDEX_WIDTH'(slot), first,
                         first + (random_word() & offset_mask), random_word()), 1'b0, '0);
    end
  endtask

  // lookup address for the given searched slot: its edges, just outside them, inside it, or a random or extreme word
  function automatic logic [63:0] pick_address(int span, int slot);
    logic [63:0] first;
    logic [63:0] last;
    if (span == 0) return ($urandom_range(0, 3) == 0) ? ALL_ONES : random_word();
    first = start_mirror[slot];
    last  = end_mirror[slot];
    case ($urandom_range(0, 9))
      0: return random_word();
      1: return $urandom_range(0, 1) ? 64'd0 : ALL_ONES;
      2, 3: return first;
      4: return last;
      5: return first - 64'd1;
      6: return last + 64'd1;
      default: begin
        if (last >= first && last - first != ALL_ONES)
          return first + random_word() % (last - first + 64'd1);
        return random_word();
      end
    endcase
  endfunction

  // compare each strobed result with the oldest pending lookup
  always @(posedge clk) begin
    response_t wanted;
    if (!rst && response_valid) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: result with no lookup pending: expected none, got hit %0b index %0d",
                 $time, response.hit, response.hit_index);
        mismatch_count++;
      end else begin
        wanted = pending_lookups.pop_front();
        if (response.hit !== wanted.hit) begin
          $display("%0t: hit mismatch: expected %0b, got %0b",
                   $time, wanted.hit, response.hit);
          mismatch_count++;
        end
        if (response.hit_index !== wanted.hit_index) begin
          $display("%0t: hit_index mismatch: expected %0d, got %0d",
                   $time, wanted.hit_index, response.hit_index);
          mismatch_count++;
        end
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d lookups pending", $time, pending_lookups.size());
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [COUNT_WIDTH-1:0] count;
    int                     span;
    int                     waited;
    int                     items;
    int                     slot;
    logic [63:0]            addr;
    response_t              typed_result;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CONFIG: set_entry_count(COUNT_WIDTH'(directed_rows[i].value));
        ROW_WRITE: begin
          issue(make_request(CMD_WRITE, INDEX_WIDTH'(directed_rows[i].value),
                             directed_rows[i].first, directed_rows[i].last, random_word()),
                1'b0, '0);
        end
        ROW_LOOKUP: begin
          typed_result.hit       = directed_rows[i].exp_hit;
          typed_result.hit_index = INDEX_WIDTH'(directed_rows[i].exp_index);
          issue(make_request(CMD_LOOKUP, INDEX_WIDTH'($urandom), random_word(), random_word(),
                             directed_rows[i].first),
                directed_rows[i].typed, typed_result);
        end
        default: ;
      endcase
    end

    // random phases: extreme counts first, then mostly small tables
    for (int phase = 0; phase < 13; phase++) begin
      if (phase < 7) begin
        count = COUNT_WIDTH'(extreme_counts[phase]);
      end else begin
        case ($urandom_range(0, 9))
          0: count = '0;
          1: count = COUNT_WIDTH'($urandom_range(49, 2047));
          default: count = COUNT_WIDTH'($urandom_range(1, 24));
        endcase
      end
      steady_sender = (phase >= 4 && phase <= 6);
      set_entry_count(count);
      span = searched_slots();
      // small tables are loaded whole, large ones only where a lookup reads
      if (span <= FULL_LOAD_LIMIT) load_sorted_ranges(span);
      items = (span <= FULL_LOAD_LIMIT) ? SMALL_PHASE_ITEMS : LARGE_PHASE_ITEMS;
      repeat (items) begin
        if ($urandom_range(0, 99) < 12) begin
          // stray write that may leave the table unsorted
          issue(make_request(CMD_WRITE, INDEX_WIDTH'($urandom), random_word(), random_word(),
                             random_word()), 1'b0, '0);
        end else begin
          slot = (span > 0) ? int'($urandom_range(0, span - 1)) : 0;
          if (span > FULL_LOAD_LIMIT) fill_slot(slot);
          addr = pick_address(span, slot);
          if (span > FULL_LOAD_LIMIT) fill_path(addr);
          issue(make_request(CMD_LOOKUP, INDEX_WIDTH'($urandom), random_word(), random_word(),
                             addr), 1'b0, '0);
        end
      end
    end
    start <= 1'b0;

    // drain the remaining results
    waited = 0;
    while (pending_lookups.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    repeat (30) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      $display("%0t: %0d lookups never answered", $time, pending_lookups.size());
      mismatch_count += pending_lookups.size();
    end
    if (mismatch_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
